### rtl/qfts_pkg.sv
// ----------------------------------------------------------------------------
// qfts_pkg
// Shared types and constants of the two-stack queue: field widths,
// operation codes, result kinds and configuration register indexes.
// ----------------------------------------------------------------------------
package qfts_pkg;

  // payload widths of the channels
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 11;
  localparam int INCAP_W = 9;
  localparam int OUTCAP_W = 11;

  // operation codes on the request channel
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_DEL = 1'b1;

  // configuration register indexes
  localparam logic CFG_IN_CAP  = 1'b0;
  localparam logic CFG_OUT_CAP = 1'b1;

  // configuration reset values
  localparam logic [INCAP_W-1:0]  IN_CAP_RST  = 9'd256;
  localparam logic [OUTCAP_W-1:0] OUT_CAP_RST = 11'd1024;

  // result kinds
  typedef enum logic [1:0] {
    KIND_OK    = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

endpackage

### rtl/qfts_if.sv
// ----------------------------------------------------------------------------
// qfts_if
// Valid/ready channels of the two-stack queue: the request channel carries
// an operation and a value, the response channel a kind and a value.
// ----------------------------------------------------------------------------
interface qfts_req_if
  import qfts_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface qfts_rsp_if
  import qfts_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic signed [VALUE_W-1:0] value_out;

  modport source (output valid, output kind, output value_out, input ready);
  modport sink   (input valid, input kind, input value_out, output ready);
endinterface

### rtl/qfts_stack_mem.sv
// ----------------------------------------------------------------------------
// qfts_stack_mem
// Simple dual-port synchronous RAM, one write and one read port, with a
// registered read that holds its data until the next read.
// ----------------------------------------------------------------------------
module qfts_stack_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/queue_from_two_stacks.sv
// ----------------------------------------------------------------------------
// queue_from_two_stacks
// First-in first-out queue built from an input stack and an output stack,
// each held in its own synchronous RAM.
// An add that lands gives no response; a delete or an error passes through
// the result state to the response register, which waits until it is free.
// A transfer of the input entries comes before the add or delete that
// starts it: one RAM access a cycle on each stack, then a wait for the last
// write to land; it ends early when the output fills and the rest is dropped.
// One transaction is worked at a time; a response may wait in its register
// while the next add is taken.
// Reset: both stacks empty, capacities 256 and 1024; RAM contents undefined.
// ----------------------------------------------------------------------------
module queue_from_two_stacks
  import qfts_pkg::*;
#(
  parameter int SMALL_MAX = 256,
  parameter int LARGE_MAX = 1024,
  parameter int DATA_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  qfts_req_if.sink         req_i,
  qfts_rsp_if.source       rsp_o
);

  localparam int ICW = $clog2(SMALL_MAX + 1);
  localparam int OCW = $clog2(LARGE_MAX + 1);
  localparam int IAW = (SMALL_MAX > 1) ? $clog2(SMALL_MAX) : 1;
  localparam int OAW = (LARGE_MAX > 1) ? $clog2(LARGE_MAX) : 1;
  localparam int SW  = (DATA_BITS < VALUE_W) ? DATA_BITS : VALUE_W;
  localparam int CW0 = (ICW > OCW) ? ICW : OCW;
  localparam int CW  = (CW0 > CFG_W) ? CW0 : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_XFER,
    ST_RESULT
  } state_e;

  state_e                 state_q, state_d;
  logic [INCAP_W-1:0]     in_cap_cfg_q;
  logic [OUTCAP_W-1:0]    out_cap_cfg_q;
  logic [ICW-1:0]         in_cnt_q, in_cnt_d;
  logic [OCW-1:0]         out_cnt_q, out_cnt_d;
  logic                   op_q, op_d;
  logic                   pend_q, pend_d;
  kind_e                  kind_q, kind_d;
  logic                   out_valid_q, out_valid_d;
  logic [SW-1:0]          val_q, val_d;
  logic [OAW-1:0]         pend_addr_q, pend_addr_d;
  logic [1:0]             out_kind_q, out_kind_d;
  logic [VALUE_W-1:0]     out_value_q, out_value_d;

  logic [CW-1:0]          in_raw, out_raw, in_clamp, in_cap, out_cap;
  logic [ICW-1:0]         in_dec;
  logic [OCW-1:0]         out_dec;
  logic                   in_full, out_room, accept, out_free;

  logic                   in_we, in_re, out_we, out_re;
  logic [IAW-1:0]         in_waddr, in_raddr;
  logic [OAW-1:0]         out_waddr, out_raddr;
  logic [SW-1:0]          in_wdata, in_rdata, out_wdata, out_rdata;

  // stack memories
  qfts_stack_mem #(.DEPTH(SMALL_MAX), .WIDTH(SW), .AW(IAW)) u_in_stack (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (in_waddr),
    .wdata_i (in_wdata),
    .re_i    (in_re),
    .raddr_i (in_raddr),
    .rdata_o (in_rdata)
  );

  qfts_stack_mem #(.DEPTH(LARGE_MAX), .WIDTH(SW), .AW(OAW)) u_out_stack (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (out_waddr),
    .wdata_i (out_wdata),
    .re_i    (out_re),
    .raddr_i (out_raddr),
    .rdata_o (out_rdata)
  );

  // effective capacities: zero acts as one, clamp to depth, input no larger
  always_comb begin
    in_raw  = CW'(in_cap_cfg_q);
    out_raw = CW'(out_cap_cfg_q);
    if (in_raw == '0) begin
      in_clamp = CW'(1);
    end else if (in_raw > CW'(SMALL_MAX)) begin
      in_clamp = CW'(SMALL_MAX);
    end else begin
      in_clamp = in_raw;
    end
    if (out_raw == '0) begin
      out_cap = CW'(1);
    end else if (out_raw > CW'(LARGE_MAX)) begin
      out_cap = CW'(LARGE_MAX);
    end else begin
      out_cap = out_raw;
    end
    in_cap = (in_clamp < out_cap) ? in_clamp : out_cap;
  end

  assign in_full  = CW'(in_cnt_q) >= in_cap;
  assign out_room = CW'(out_cnt_q) < out_cap;
  assign in_dec   = in_cnt_q - ICW'(1);
  assign out_dec  = out_cnt_q - OCW'(1);

  // handshakes
  assign req_i.ready     = (state_q == ST_IDLE);
  assign accept          = req_i.valid && req_i.ready;
  assign out_free        = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.kind      = out_kind_q;
  assign rsp_o.value_out = out_value_q;

  // sequencer: push, pop and the stack-to-stack transfer
  always_comb begin
    state_d     = state_q;
    in_cnt_d    = in_cnt_q;
    out_cnt_d   = out_cnt_q;
    op_d        = op_q;
    pend_d      = 1'b0;
    kind_d      = kind_q;
    val_d       = val_q;
    pend_addr_d = pend_addr_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;

    in_we     = 1'b0;
    in_waddr  = in_cnt_q[IAW-1:0];
    in_wdata  = req_i.value[SW-1:0];
    in_re     = 1'b0;
    in_raddr  = in_dec[IAW-1:0];
    out_we    = pend_q;
    out_waddr = pend_addr_q;
    out_wdata = in_rdata;
    out_re    = 1'b0;
    out_raddr = out_dec[OAW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.func == FUNC_ADD) begin
            if (!in_full) begin
              in_we    = 1'b1;
              in_cnt_d = in_cnt_q + ICW'(1);
            end else if (out_cnt_q != '0) begin
              kind_d  = KIND_FULL;
              state_d = ST_RESULT;
            end else begin
              op_d    = FUNC_ADD;
              val_d   = req_i.value[SW-1:0];
              state_d = ST_XFER;
            end
          end else begin
            if (out_cnt_q != '0) begin
              out_re    = 1'b1;
              out_cnt_d = out_dec;
              kind_d    = KIND_OK;
              state_d   = ST_RESULT;
            end else if (in_cnt_q == '0) begin
              kind_d  = KIND_EMPTY;
              state_d = ST_RESULT;
            end else begin
              op_d    = FUNC_DEL;
              state_d = ST_XFER;
            end
          end
        end
      end

      ST_XFER: begin
        if (in_cnt_q != '0) begin
          // move newest input entry; drop the rest once the output is full
          if (out_room) begin
            in_re       = 1'b1;
            in_cnt_d    = in_dec;
            pend_d      = 1'b1;
            pend_addr_d = out_cnt_q[OAW-1:0];
            out_cnt_d   = out_cnt_q + OCW'(1);
          end else begin
            in_cnt_d = '0;
          end
        end else if (!pend_q) begin
          // transfer done, finish the waiting operation
          if (op_q == FUNC_ADD) begin
            in_we    = 1'b1;
            in_wdata = val_q;
            in_cnt_d = ICW'(1);
            state_d  = ST_IDLE;
          end else begin
            out_re    = 1'b1;
            out_cnt_d = out_dec;
            kind_d    = KIND_OK;
            state_d   = ST_RESULT;
          end
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_value_d = (kind_q == KIND_OK) ? VALUE_W'(out_rdata) : '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state, configuration and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      in_cap_cfg_q  <= IN_CAP_RST;
      out_cap_cfg_q <= OUT_CAP_RST;
      in_cnt_q      <= '0;
      out_cnt_q     <= '0;
      op_q          <= FUNC_ADD;
      pend_q        <= 1'b0;
      kind_q        <= KIND_OK;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      op_q        <= op_d;
      pend_q      <= pend_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IN_CAP:  in_cap_cfg_q  <= cfg_data_i[INCAP_W-1:0];
          CFG_OUT_CAP: out_cap_cfg_q <= cfg_data_i[OUTCAP_W-1:0];
          default: begin
            in_cap_cfg_q <= in_cap_cfg_q;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    pend_addr_q <= pend_addr_d;
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
  end

endmodule
